// ===== hw/rtl/dsv_pkg.sv =====
package dsv_pkg;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SUBGROUP_ORDER = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_MODULUS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GENERATOR      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_KEY     = 2'd3;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'b00000000000000001,
        ST_INV_CHK  = 17'b00000000000000010,
        ST_INV_MUL  = 17'b00000000000000100,
        ST_INV_UPD  = 17'b00000000000001000,
        ST_U1       = 17'b00000000000010000,
        ST_U2       = 17'b00000000000100000,
        ST_GRED     = 17'b00000000001000000,
        ST_PW_START = 17'b00000000010000000,
        ST_PW_BIT   = 17'b00000000100000000,
        ST_PW_ACC   = 17'b00000001000000000,
        ST_PW_SQ    = 17'b00000010000000000,
        ST_PW_NXT   = 17'b00000100000000000,
        ST_VRED     = 17'b00001000000000000,
        ST_CMP      = 17'b00010000000000000,
        ST_FINISH   = 17'b00100000000000000,
        ST_DIV      = 17'b01000000000000000,
        ST_MUL      = 17'b10000000000000000
    } state_t;

endpackage

// ===== hw/rtl/dsa_signature_verify_core.sv =====
// Operation: range-check rejects skip straight to the result. A full verify runs extended
// Euclid on s mod q (per step a bit-serial divide plus a bit-serial modular multiply),
// then two square-and-multiply powers mod p.
// Throughput: one word at a time; the shared divider and modular multiplier set it.
// Reset: config registers clear to zero, control returns to idle, output empty.
module dsa_signature_verify_core
    import dsv_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [WORD_BITS-1:0]    sig_r,
    input  logic [WORD_BITS-1:0]    sig_s,
    input  logic [WORD_BITS-1:0]    digest,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    valid_res
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] a,
        input logic [WORD_BITS-1:0] b,
        input logic [WORD_BITS-1:0] m
    );
        logic [WORD_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m})
            sum = sum - {1'b0, m};
        return sum[WORD_BITS-1:0];
    endfunction

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;
    logic   res_reg, res_next;
    logic   vd_reg, vd_next;
    logic   second_reg, second_next;

    logic [WORD_BITS-1:0] q_reg, p_reg, g_reg, y_reg;
    logic [WORD_BITS-1:0] r_reg, r_next, h_reg, h_next;
    logic [WORD_BITS-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [WORD_BITS-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [WORD_BITS-1:0] u1_reg, u1_next, u2_reg, u2_next, a_reg, a_next;
    logic [WORD_BITS-1:0] pw_acc_reg, pw_acc_next, pw_base_reg, pw_base_next;
    logic [WORD_BITS-1:0] pw_e_reg, pw_e_next;
    logic [WORD_BITS-1:0] dv_num_reg, dv_num_next, dv_rem_reg, dv_rem_next;
    logic [WORD_BITS-1:0] dv_den_reg, dv_den_next;
    logic [CNT_W-1:0]     dv_cnt_reg, dv_cnt_next;
    logic [WORD_BITS-1:0] mm_acc_reg, mm_acc_next, mm_x_reg, mm_x_next;
    logic [WORD_BITS-1:0] mm_y_reg, mm_y_next, mm_m_reg, mm_m_next;

    logic               in_take;
    logic               out_free;
    logic [WORD_BITS:0] dv_trial;
    logic [WORD_BITS-1:0] qt_red;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign valid_res = res_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign dv_trial  = {dv_rem_reg, dv_num_reg[WORD_BITS-1]};
    assign qt_red    = (dv_num_reg == q_reg) ? '0 : dv_num_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        vd_next        = vd_reg;
        second_next    = second_reg;
        r_next = r_reg;  h_next = h_reg;
        r0_next = r0_reg;  r1_next = r1_reg;  t0_next = t0_reg;  t1_next = t1_reg;
        u1_next = u1_reg;  u2_next = u2_reg;  a_next = a_reg;
        pw_acc_next = pw_acc_reg;  pw_base_next = pw_base_reg;  pw_e_next = pw_e_reg;
        dv_num_next = dv_num_reg;  dv_rem_next = dv_rem_reg;
        dv_den_next = dv_den_reg;  dv_cnt_next = dv_cnt_reg;
        mm_acc_next = mm_acc_reg;  mm_x_next = mm_x_reg;
        mm_y_next = mm_y_reg;  mm_m_next = mm_m_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    r_next  = sig_r;
                    h_next  = digest;
                    r0_next = q_reg;
                    r1_next = sig_s;
                    t0_next = '0;
                    t1_next = ONE;
                    second_next = 1'b0;
                    if (sig_r == '0 || sig_s == '0 || sig_r >= q_reg || sig_s >= q_reg
                        || p_reg == '0)
                    begin
                        vd_next    = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                        state_next = ST_INV_CHK;
                end
            end
            ST_INV_CHK:
            begin
                dv_rem_next = '0;
                dv_cnt_next = '0;
                if (r1_reg == '0)
                begin
                    if (r0_reg != ONE)
                    begin
                        vd_next    = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        dv_num_next = h_reg;
                        dv_den_next = q_reg;
                        ret_next    = ST_U1;
                        state_next  = ST_DIV;
                    end
                end
                else
                begin
                    dv_num_next = r0_reg;
                    dv_den_next = r1_reg;
                    ret_next    = ST_INV_MUL;
                    state_next  = ST_DIV;
                end
            end
            ST_INV_MUL:
            begin
                mm_acc_next = '0;
                mm_x_next   = qt_red;
                mm_y_next   = t1_reg;
                mm_m_next   = q_reg;
                r0_next     = r1_reg;
                r1_next     = dv_rem_reg;
                ret_next    = ST_INV_UPD;
                state_next  = ST_MUL;
            end
            ST_INV_UPD:
            begin
                t0_next = t1_reg;
                if (t0_reg >= mm_acc_reg)
                    t1_next = t0_reg - mm_acc_reg;
                else
                    t1_next = t0_reg - mm_acc_reg + q_reg;
                state_next = ST_INV_CHK;
            end
            ST_U1:
            begin
                mm_acc_next = '0;
                mm_x_next   = dv_rem_reg;
                mm_y_next   = t0_reg;
                mm_m_next   = q_reg;
                ret_next    = ST_U2;
                state_next  = ST_MUL;
            end
            ST_U2:
            begin
                u1_next     = mm_acc_reg;
                mm_acc_next = '0;
                mm_x_next   = r_reg;
                mm_y_next   = t0_reg;
                mm_m_next   = q_reg;
                ret_next    = ST_GRED;
                state_next  = ST_MUL;
            end
            ST_GRED:
            begin
                u2_next     = mm_acc_reg;
                dv_num_next = g_reg;
                dv_den_next = p_reg;
                dv_rem_next = '0;
                dv_cnt_next = '0;
                ret_next    = ST_PW_START;
                state_next  = ST_DIV;
            end
            ST_PW_START:
            begin
                pw_base_next = dv_rem_reg;
                pw_acc_next  = (p_reg == ONE) ? '0 : ONE;
                pw_e_next    = second_reg ? u2_reg : u1_reg;
                state_next   = ST_PW_BIT;
            end
            ST_PW_BIT:
            begin
                mm_acc_next = '0;
                mm_m_next   = p_reg;
                if (pw_e_reg == '0)
                begin
                    if (!second_reg)
                    begin
                        a_next      = pw_acc_reg;
                        second_next = 1'b1;
                        dv_num_next = y_reg;
                        dv_den_next = p_reg;
                        dv_rem_next = '0;
                        dv_cnt_next = '0;
                        ret_next    = ST_PW_START;
                        state_next  = ST_DIV;
                    end
                    else
                    begin
                        mm_x_next  = a_reg;
                        mm_y_next  = pw_acc_reg;
                        ret_next   = ST_VRED;
                        state_next = ST_MUL;
                    end
                end
                else if (pw_e_reg[0])
                begin
                    mm_x_next  = pw_acc_reg;
                    mm_y_next  = pw_base_reg;
                    ret_next   = ST_PW_ACC;
                    state_next = ST_MUL;
                end
                else
                    state_next = ST_PW_SQ;
            end
            ST_PW_ACC:
            begin
                pw_acc_next = mm_acc_reg;
                state_next  = ST_PW_SQ;
            end
            ST_PW_SQ:
            begin
                mm_acc_next = '0;
                mm_x_next   = pw_base_reg;
                mm_y_next   = pw_base_reg;
                mm_m_next   = p_reg;
                ret_next    = ST_PW_NXT;
                state_next  = ST_MUL;
            end
            ST_PW_NXT:
            begin
                pw_base_next = mm_acc_reg;
                pw_e_next    = pw_e_reg >> 1;
                state_next   = ST_PW_BIT;
            end
            ST_VRED:
            begin
                dv_num_next = mm_acc_reg;
                dv_den_next = q_reg;
                dv_rem_next = '0;
                dv_cnt_next = '0;
                ret_next    = ST_CMP;
                state_next  = ST_DIV;
            end
            ST_CMP:
            begin
                vd_next    = (dv_rem_reg == r_reg);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_next       = vd_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (dv_trial >= {1'b0, dv_den_reg})
                begin
                    dv_rem_next = WORD_BITS'(dv_trial - {1'b0, dv_den_reg});
                    dv_num_next = {dv_num_reg[WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next = dv_trial[WORD_BITS-1:0];
                    dv_num_next = {dv_num_reg[WORD_BITS-2:0], 1'b0};
                end
                dv_cnt_next = dv_cnt_reg + 1'b1;
                if (dv_cnt_reg == CNT_LAST)
                    state_next = ret_reg;
            end
            ST_MUL:
            begin
                if (mm_y_reg == '0)
                    state_next = ret_reg;
                else
                begin
                    if (mm_y_reg[0])
                        mm_acc_next = add_mod(mm_acc_reg, mm_x_reg, mm_m_reg);
                    mm_x_next = add_mod(mm_x_reg, mm_x_reg, mm_m_reg);
                    mm_y_next = mm_y_reg >> 1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
            res_reg       <= 1'b0;
            vd_reg        <= 1'b0;
            second_reg    <= 1'b0;
            q_reg         <= '0;
            p_reg         <= '0;
            g_reg         <= '0;
            y_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            vd_reg        <= vd_next;
            second_reg    <= second_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SUBGROUP_ORDER: q_reg <= cfg_data;
                    CFG_FIELD_MODULUS:  p_reg <= cfg_data;
                    CFG_GENERATOR:      g_reg <= cfg_data;
                    CFG_PUBLIC_KEY:     y_reg <= cfg_data;
                    default:            q_reg <= q_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;  h_reg <= h_next;
        r0_reg <= r0_next;  r1_reg <= r1_next;  t0_reg <= t0_next;  t1_reg <= t1_next;
        u1_reg <= u1_next;  u2_reg <= u2_next;  a_reg <= a_next;
        pw_acc_reg <= pw_acc_next;  pw_base_reg <= pw_base_next;  pw_e_reg <= pw_e_next;
        dv_num_reg <= dv_num_next;  dv_rem_reg <= dv_rem_next;
        dv_den_reg <= dv_den_next;  dv_cnt_reg <= dv_cnt_next;
        mm_acc_reg <= mm_acc_next;  mm_x_reg <= mm_x_next;
        mm_y_reg <= mm_y_next;  mm_m_reg <= mm_m_next;
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ST_IDLE)
        else $error("accepted word did not start work");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && $past(state_reg) == ST_DIV |-> dv_rem_reg < dv_den_reg)
        else $error("divider remainder out of range");

    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> mm_acc_reg < mm_m_reg && mm_x_reg < mm_m_reg)
        else $error("modular multiplier operand out of range");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result word without finished verify");

endmodule
